@@ src/aabb_collision_resolve_core_macros.svh @@
// Assertion macros for the collision resolve core.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef AABB_COLLISION_RESOLVE_CORE_MACROS_SVH
`define AABB_COLLISION_RESOLVE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CR_ASSERT_HOLDS(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("collision core check failed");
`define CR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("collision core check failed");
`else
`define CR_ASSERT_HOLDS(lbl, ante, cons)
`define CR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/aabb_cr_pkg.sv @@
// Types, codes and helper functions of the collision resolve core.
// No dependencies; used by aabb_cr_calc and aabb_collision_resolve_core.
`timescale 1ns / 1ps

package aabb_cr_pkg;

	localparam int CW     = 20;
	localparam int PADDR_W = 3;

	localparam logic REG_BOUNCE   = 1'b0;
	localparam logic REG_PLATFORM = 1'b1;

	typedef enum logic [2:0] {
		SIDE_NONE   = 3'd0,
		SIDE_TOP    = 3'd1,
		SIDE_BOTTOM = 3'd2,
		SIDE_LEFT   = 3'd3,
		SIDE_RIGHT  = 3'd4
	} side_t;

	typedef struct packed {
		logic bounce_enable;
		logic platform_only;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] mover_x;
		logic signed [15:0] mover_y;
		logic signed [15:0] mover_box_dx;
		logic signed [15:0] mover_box_dy;
		logic [11:0]        mover_width;
		logic [11:0]        mover_height;
		logic signed [15:0] mover_vel_x;
		logic signed [15:0] mover_vel_y;
		logic signed [15:0] block_left;
		logic signed [15:0] block_top;
		logic [11:0]        block_width;
		logic [11:0]        block_height;
	} item_t;

	typedef struct packed {
		side_t              side;
		logic signed [15:0] new_x;
		logic signed [15:0] new_y;
		logic signed [15:0] new_vel_x;
		logic signed [15:0] new_vel_y;
		logic               landed;
	} result_t;

	function automatic logic signed [CW-1:0] sx16(input logic signed [15:0] v);
		return {{(CW-16){v[15]}}, v};
	endfunction

	function automatic logic signed [CW-1:0] zx12(input logic [11:0] v);
		return {{(CW-12){1'b0}}, v};
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767)
			r = 16'sh7fff;
		else if (v < -20'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
		logic signed [15:0] r;
		if (v == 16'sh8000)
			r = 16'sh7fff;
		else
			r = 16'(-v);
		return r;
	endfunction

endpackage

@@ src/aabb_collision_resolve_core.sv @@
// Top level of the box collision resolve core: input and result registers, APB registers.
// Depends on aabb_cr_pkg, aabb_cr_calc and aabb_collision_resolve_core_macros.svh.
//
//   channel   handshake             payload
//   in        in_valid / in_ready   mover_*, block_* fields
//   out       out_valid / out_ready contact_side, new_*, landed
//   apb       psel penable pwrite   paddr, pwdata, prdata (pready tied high)
//
// One beat per cycle unless the output stalls; a beat passes the input register and then the result register,
// with the whole response computed in one combinational pass between the two registers.
// arst_n clears both valid flags and the two config registers.
// A stalled result holds; the input register takes one more beat if it is empty, then in_ready drops.
`timescale 1ns / 1ps

`include "aabb_collision_resolve_core_macros.svh"

module aabb_collision_resolve_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [aabb_cr_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [15:0]                mover_x,
	input  logic signed [15:0]                mover_y,
	input  logic signed [15:0]                mover_box_dx,
	input  logic signed [15:0]                mover_box_dy,
	input  logic [11:0]                       mover_width,
	input  logic [11:0]                       mover_height,
	input  logic signed [15:0]                mover_vel_x,
	input  logic signed [15:0]                mover_vel_y,
	input  logic signed [15:0]                block_left,
	input  logic signed [15:0]                block_top,
	input  logic [11:0]                       block_width,
	input  logic [11:0]                       block_height,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        contact_side,
	output logic signed [15:0]                new_x,
	output logic signed [15:0]                new_y,
	output logic signed [15:0]                new_vel_x,
	output logic signed [15:0]                new_vel_y,
	output logic                              landed
);

	aabb_cr_pkg::cfg_t    cfg_q;
	aabb_cr_pkg::item_t   item_in, item_s1;
	aabb_cr_pkg::result_t res_comb, res_s2;
	logic valid_s1, valid_s2, adv_s1, wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				aabb_cr_pkg::REG_BOUNCE:   cfg_q.bounce_enable <= pwdata[0];
				aabb_cr_pkg::REG_PLATFORM: cfg_q.platform_only <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			aabb_cr_pkg::REG_BOUNCE:   prdata = {31'd0, cfg_q.bounce_enable};
			aabb_cr_pkg::REG_PLATFORM: prdata = {31'd0, cfg_q.platform_only};
			default:                   prdata = 32'd0;
		endcase
	end

	assign item_in = '{mover_x, mover_y, mover_box_dx, mover_box_dy, mover_width,
		mover_height, mover_vel_x, mover_vel_y, block_left, block_top,
		block_width, block_height};

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (!valid_s2 || out_ready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= item_in;
		if (adv_s1)
			res_s2 <= res_comb;
	end

	aabb_cr_calc u_calc (
		.item (item_s1),
		.cfg  (cfg_q),
		.res  (res_comb)
	);

	assign out_valid    = valid_s2;
	assign contact_side = res_s2.side;
	assign new_x        = res_s2.new_x;
	assign new_y        = res_s2.new_y;
	assign new_vel_x    = res_s2.new_vel_x;
	assign new_vel_y    = res_s2.new_vel_y;
	assign landed       = res_s2.landed;

	`CR_ASSERT_HOLDS(a_landed_top, valid_s2 && res_s2.landed, res_s2.side == aabb_cr_pkg::SIDE_TOP)
	`CR_ASSERT_HOLDS(a_none_no_land, valid_s2 && res_s2.side == aabb_cr_pkg::SIDE_NONE, !res_s2.landed)
	`CR_ASSERT_NEXT(a_full_stall_holds, valid_s1 && valid_s2 && !out_ready, valid_s1 && valid_s2)

endmodule

@@ src/aabb_cr_calc.sv @@
// Overlap test, contact side choice, snap and velocity response for one beat.
// Purely combinational; depends on aabb_cr_pkg.
`timescale 1ns / 1ps

module aabb_cr_calc (
	input  aabb_cr_pkg::item_t   item,
	input  aabb_cr_pkg::cfg_t    cfg,
	output aabb_cr_pkg::result_t res
);

	logic signed [aabb_cr_pkg::CW-1:0] x1, y1, x2, y2, w1, h1, w2, h2;
	logic signed [aabb_cr_pkg::CW-1:0] cx1, cy1, cx2, cy2, dx, dy, adx, ady, gx, gy;
	logic signed [aabb_cr_pkg::CW-1:0] bdx, bdy;
	logic [12:0] wsum, hsum;
	logic overlap;
	aabb_cr_pkg::side_t side;

	always_comb begin
		bdx = aabb_cr_pkg::sx16(item.mover_box_dx);
		bdy = aabb_cr_pkg::sx16(item.mover_box_dy);
		x1 = aabb_cr_pkg::sx16(item.mover_x) + bdx;
		y1 = aabb_cr_pkg::sx16(item.mover_y) + bdy;
		x2 = aabb_cr_pkg::sx16(item.block_left);
		y2 = aabb_cr_pkg::sx16(item.block_top);
		w1 = aabb_cr_pkg::zx12(item.mover_width);
		h1 = aabb_cr_pkg::zx12(item.mover_height);
		w2 = aabb_cr_pkg::zx12(item.block_width);
		h2 = aabb_cr_pkg::zx12(item.block_height);

		cx1 = x1 + aabb_cr_pkg::zx12({1'b0, item.mover_width[11:1]});
		cy1 = y1 + aabb_cr_pkg::zx12({1'b0, item.mover_height[11:1]});
		cx2 = x2 + aabb_cr_pkg::zx12({1'b0, item.block_width[11:1]});
		cy2 = y2 + aabb_cr_pkg::zx12({1'b0, item.block_height[11:1]});
		dx = cx1 - cx2;
		dy = cy1 - cy2;
		adx = dx[aabb_cr_pkg::CW-1] ? -dx : dx;
		ady = dy[aabb_cr_pkg::CW-1] ? -dy : dy;
		wsum = {1'b0, item.mover_width} + {1'b0, item.block_width};
		hsum = {1'b0, item.mover_height} + {1'b0, item.block_height};
		gx = adx - aabb_cr_pkg::zx12(wsum[12:1]) + 20'sd1;
		gy = ady - aabb_cr_pkg::zx12(hsum[12:1]) + 20'sd1;

		overlap = (x1 + w1 > x2) && (x2 + w2 > x1) && (y1 + h1 > y2) && (y2 + h2 > y1);

		side = aabb_cr_pkg::SIDE_NONE;
		if (overlap) begin
			if (gx > gy)
				side = (cx1 < cx2) ? aabb_cr_pkg::SIDE_LEFT : aabb_cr_pkg::SIDE_RIGHT;
			else
				side = (cy1 < cy2) ? aabb_cr_pkg::SIDE_TOP : aabb_cr_pkg::SIDE_BOTTOM;
		end
		if (cfg.platform_only &&
		    !(side == aabb_cr_pkg::SIDE_TOP && !item.mover_vel_y[15]))
			side = aabb_cr_pkg::SIDE_NONE;

		res.side      = side;
		res.new_x     = item.mover_x;
		res.new_y     = item.mover_y;
		res.new_vel_x = item.mover_vel_x;
		res.new_vel_y = item.mover_vel_y;
		res.landed    = 1'b0;

		case (side)
			aabb_cr_pkg::SIDE_TOP: begin
				res.new_y = aabb_cr_pkg::sat16(y2 - h1 - bdy + 20'sd1);
				if (item.mover_vel_y > 16'sd0)
					res.new_vel_y = 16'sd0;
				res.landed = 1'b1;
			end
			aabb_cr_pkg::SIDE_BOTTOM: begin
				res.new_y = aabb_cr_pkg::sat16(y2 + h2 - bdy - 20'sd1);
				if (item.mover_vel_y[15])
					res.new_vel_y = 16'sd0;
			end
			aabb_cr_pkg::SIDE_RIGHT: begin
				res.new_x = aabb_cr_pkg::sat16(x2 + w2 - bdx - 20'sd1);
				if (item.mover_vel_x[15])
					res.new_vel_x = cfg.bounce_enable ?
						aabb_cr_pkg::neg_sat16(item.mover_vel_x) : 16'sd0;
			end
			aabb_cr_pkg::SIDE_LEFT: begin
				res.new_x = aabb_cr_pkg::sat16(x2 - w1 - bdx + 20'sd1);
				if (item.mover_vel_x > 16'sd0)
					res.new_vel_x = cfg.bounce_enable ?
						aabb_cr_pkg::neg_sat16(item.mover_vel_x) : 16'sd0;
			end
			default: begin
			end
		endcase
	end

endmodule
